// ===== sv/dtrs_pkg.sv =====
// ----------------------------------------------------------------------------
// dtrs_pkg
// Shared opcodes, field widths and the slot write command type for the
// delayed task ready scheduler.
// ----------------------------------------------------------------------------
package dtrs_pkg;

  // field widths
  localparam int OP_W    = 3;
  localparam int ID_W    = 4;
  localparam int DELAY_W = 16;

  // largest slot count that a 4-bit id can address
  localparam int MAX_SLOTS = 16;

  // command opcodes
  localparam logic [OP_W-1:0] OP_QUEUE         = 3'd0;
  localparam logic [OP_W-1:0] OP_QUEUE_DELAYED = 3'd1;
  localparam logic [OP_W-1:0] OP_UNQUEUE       = 3'd2;
  localparam logic [OP_W-1:0] OP_TICK          = 3'd3;
  localparam logic [OP_W-1:0] OP_DISPATCH      = 3'd4;

  // write command for one slot cell
  typedef struct packed {
    logic               wr_en;
    logic               active;
    logic               load_delay;
    logic [DELAY_W-1:0] delay;
  } dtrs_wr_t;

endpackage

// ===== sv/dtrs_cell.sv =====
// ----------------------------------------------------------------------------
// dtrs_cell
// One task slot: active flag and delay counter. Either takes its neighbor's
// contents during a rotation or applies a direct slot write.
// ----------------------------------------------------------------------------
module dtrs_cell
  import dtrs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               shift_en,
  input  dtrs_wr_t           wr,
  input  logic               nb_active,
  input  logic [DELAY_W-1:0] nb_delay,
  output logic               active,
  output logic [DELAY_W-1:0] delay
);

  // slot storage
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      delay  <= '0;
    end else if (shift_en) begin
      active <= nb_active;
      delay  <= nb_delay;
    end else if (wr.wr_en) begin
      active <= wr.active;
      if (wr.load_delay) begin
        delay <= wr.delay;
      end
    end
  end

endmodule

// ===== sv/dtrs_head.sv =====
// ----------------------------------------------------------------------------
// dtrs_head
// Slot processing at the head of the ring: tick decrement on the way back
// to the tail and ready detection for the dispatch scan.
// ----------------------------------------------------------------------------
module dtrs_head
  import dtrs_pkg::*;
(
  input  logic               do_tick,
  input  logic               active,
  input  logic [DELAY_W-1:0] delay,
  output logic [DELAY_W-1:0] delay_out,
  output logic               ready
);

  logic nonzero;

  // decrement active slots whose delay has not run out
  assign nonzero   = (delay != '0);
  assign delay_out = (do_tick && active && nonzero) ? delay - DELAY_W'(1) : delay;

  // ready when active with no delay left
  assign ready = active && !nonzero;

endmodule

// ===== sv/delayed_task_ready_scheduler.sv =====
// Queue, queue delayed and unqueue write one slot directly; tick rotates the ring.
// Dispatch walks the slot ring one slot per cycle, holding while a ready slot
// meets a stalled output, then emits the final result.
// The ring of slot cells rotates once per tick or dispatch, and no new command
// is accepted until that command is finished.
// Synchronous active-high reset clears every slot (inactive, zero delay).
// ----------------------------------------------------------------------------
// delayed_task_ready_scheduler
// Task slot table held in a rotating chain of cells; tick and dispatch
// process the slot passing through the head cell on each rotation step.
// ----------------------------------------------------------------------------
module delayed_task_ready_scheduler
  import dtrs_pkg::*;
#(
  parameter int NUM_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // opcode[2:0], task_id[6:3], delay_ticks[22:7]
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // ready_id[3:0]
  output logic [0:0]  m_tuser,   // found[0]
  output logic        m_tlast    // last
);

  localparam int SLOTS = (NUM_TASKS < MAX_SLOTS) ? NUM_TASKS : MAX_SLOTS;
  localparam int CW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [CW-1:0] CNT_LAST = CW'(SLOTS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_TICK = 2'd1;
  localparam logic [1:0] ST_SCAN = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]         state, state_next;
  logic [CW-1:0]      cnt, cnt_next;
  logic               pend_valid, pend_valid_next;
  logic [ID_W-1:0]    pend_id, pend_id_next;

  logic [OP_W-1:0]    in_op;
  logic [ID_W-1:0]    in_id;
  logic [DELAY_W-1:0] in_delay;
  logic               s_accept;
  logic               slot_cmd;

  logic               cell_active [SLOTS];
  logic [DELAY_W-1:0] cell_delay  [SLOTS];
  dtrs_wr_t           cell_wr     [SLOTS];

  logic [DELAY_W-1:0] head_delay;
  logic               head_ready;
  logic               step;
  logic               out_busy;
  logic               out_load;
  logic [ID_W-1:0]    out_id;
  logic               out_found;
  logic               out_last;

  // input unpacking
  assign in_op    = s_tdata[2:0];
  assign in_id    = s_tdata[6:3];
  assign in_delay = s_tdata[22:7];
  assign s_tready = (state == ST_IDLE);
  assign s_accept = s_tvalid && s_tready;

  always_comb begin
    slot_cmd = s_accept && (in_op inside {OP_QUEUE, OP_QUEUE_DELAYED, OP_UNQUEUE});
  end

  // chain of slot cells, rotating toward cell 0
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic               nb_active;
    logic [DELAY_W-1:0] nb_delay;

    if (i == SLOTS - 1) begin : g_tail
      assign nb_active = cell_active[0];
      assign nb_delay  = head_delay;
    end else begin : g_mid
      assign nb_active = cell_active[i+1];
      assign nb_delay  = cell_delay[i+1];
    end

    always_comb begin
      cell_wr[i].wr_en      = slot_cmd && (in_id == ID_W'(i));
      cell_wr[i].active     = (in_op != OP_UNQUEUE);
      cell_wr[i].load_delay = (in_op != OP_UNQUEUE);
      cell_wr[i].delay      = (in_op == OP_QUEUE_DELAYED) ? in_delay : '0;
    end

    dtrs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .shift_en  (step),
      .wr        (cell_wr[i]),
      .nb_active (nb_active),
      .nb_delay  (nb_delay),
      .active    (cell_active[i]),
      .delay     (cell_delay[i])
    );
  end

  // head slot processing
  dtrs_head u_head (
    .do_tick   (state == ST_TICK),
    .active    (cell_active[0]),
    .delay     (cell_delay[0]),
    .delay_out (head_delay),
    .ready     (head_ready)
  );

  assign out_busy = m_tvalid && !m_tready;

  // sequencer: rotation, pending result and output loading
  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    pend_valid_next = pend_valid;
    pend_id_next    = pend_id;
    step            = 1'b0;
    out_load        = 1'b0;
    out_id          = pend_id;
    out_found       = 1'b1;
    out_last        = 1'b0;
    case (state)
      ST_IDLE: begin
        cnt_next = '0;
        if (s_accept && in_op == OP_TICK) begin
          state_next = ST_TICK;
        end else if (s_accept && in_op == OP_DISPATCH) begin
          state_next = ST_SCAN;
        end
      end
      ST_TICK: begin
        step     = 1'b1;
        cnt_next = cnt + CW'(1);
        if (cnt == CNT_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        step = !(head_ready && pend_valid && out_busy);
        if (step) begin
          cnt_next = cnt + CW'(1);
          if (head_ready) begin
            // a newer ready slot means the held one is not the last
            out_load        = pend_valid;
            pend_valid_next = 1'b1;
            pend_id_next    = ID_W'(cnt);
          end
          if (cnt == CNT_LAST) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        if (!out_busy) begin
          out_load        = 1'b1;
          out_found       = pend_valid;
          out_id          = pend_valid ? pend_id : '0;
          out_last        = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      pend_valid <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      pend_valid <= pend_valid_next;
      m_tvalid   <= out_load || (m_tvalid && !m_tready);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_id <= pend_id_next;
    if (out_load) begin
      m_tdata <= {4'b0000, out_id};
      m_tuser <= out_found;
      m_tlast <= out_last;
    end
  end

`ifndef SYNTHESIS
  // nothing held over once the block is idle
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !pend_valid)
    else $error("pending result left over after a scan");

  // a result without a ready task ends the scan
  a_notfound_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("not-found result without last");

  // a tick rotation returns to idle after its last slot
  a_tick_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_TICK && cnt == CNT_LAST |=> state == ST_IDLE)
    else $error("tick rotation did not finish");

  // the output register is never overwritten while stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !out_busy)
    else $error("result loaded over a stalled transaction");
`endif

endmodule
